FILE: sv/draw_request_admission_guard_core_assert.svh
// Assertion macros for the draw request admission guard.
// Expects clk and rst_n in the scope of use.
`ifndef DRAW_REQUEST_ADMISSION_GUARD_CORE_ASSERT_SVH
`define DRAW_REQUEST_ADMISSION_GUARD_CORE_ASSERT_SVH

// same-cycle implication
`define DRAG_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DRAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/drag_pkg.sv
// Shared types and constants of the draw request admission guard.
// No dependencies.
package drag_pkg;

    localparam int COORD_BITS     = 16;
    localparam int PIXEL_BITS     = 40;
    localparam int FB_BITS        = 12;
    localparam int OPS_BITS       = 24;
    localparam int FAULT_BITS     = 8;
    localparam int KIND_BITS      = 2;
    localparam int CMD_BITS       = 3;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = PIXEL_BITS;
    localparam int PROD_BITS      = 2 * FB_BITS;
    // signed compare width: holds coords, frame size and coord differences
    localparam int CMP_BITS = ((COORD_BITS + 1 > FB_BITS) ? COORD_BITS + 1 : FB_BITS) + 1;

    localparam logic [KIND_BITS-1:0] KIND_DRAW   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_RAW    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RESET  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_PIXEL  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_LINE   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_RECT   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CIRCLE = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DISABLED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_INVALID  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_BUDGET   = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_W     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_H     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PIXELS  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_OPS     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAULT_LIMIT = 3'd4;

    localparam logic [FB_BITS-1:0]    RST_FRAME_W     = 12'd640;
    localparam logic [FB_BITS-1:0]    RST_FRAME_H     = 12'd480;
    localparam logic [PIXEL_BITS-1:0] RST_MAX_PIXELS  = PIXEL_BITS'(64'd16777216);
    localparam logic [OPS_BITS-1:0]   RST_MAX_OPS     = 24'd4096;
    localparam logic [FAULT_BITS-1:0] RST_FAULT_LIMIT = 8'd8;

    typedef struct packed {
        logic [FB_BITS-1:0]    frame_w;
        logic [FB_BITS-1:0]    frame_h;
        logic [PIXEL_BITS-1:0] max_pixels;
        logic [OPS_BITS-1:0]   max_ops;
        logic [FAULT_BITS-1:0] fault_limit;
    } cfg_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]         kind;
        logic [CMD_BITS-1:0]          command;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] extent_w;
        logic signed [COORD_BITS-1:0] extent_h;
        logic [PIXEL_BITS-1:0]        pixel_count;
    } item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic                  geom_ok;
        logic [PIXEL_BITS-1:0] est;
    } est_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [PIXEL_BITS-1:0]  est_pixels;
        logic                   guard_enabled;
        logic [FAULT_BITS-1:0]  fault_total;
    } result_t;

endpackage

FILE: sv/draw_request_admission_guard_core.sv
// Draw request admission guard: an accepted request passes through the input register,
// the estimate stage and the ledger stage into the result register.
// Throughput is one transaction per cycle while the result register is empty or
// being taken; the whole pipeline advances together, held only by that one stall.
// Asynchronous active-low reset restores register defaults, enables the guard and
// clears faults, op count and pixel total; the pipeline starts empty.
module draw_request_admission_guard_core
    import drag_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [KIND_BITS-1:0]         kind,
    input  logic [CMD_BITS-1:0]          command,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] extent_w,
    input  logic signed [COORD_BITS-1:0] extent_h,
    input  logic [PIXEL_BITS-1:0]        pixel_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [STATUS_BITS-1:0]       status,
    output logic [PIXEL_BITS-1:0]        est_pixels,
    output logic                         guard_enabled,
    output logic [FAULT_BITS-1:0]        fault_total
);

    cfg_t    cfg;
    logic    adv;
    logic    item_valid_reg;
    item_t   item_reg;
    logic    est_valid;
    est_t    est;
    logic    res_valid;
    result_t res;

    assign adv      = !res_valid || out_ready;
    assign in_ready = adv;

    drag_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            item_reg.kind        <= kind;
            item_reg.command     <= command;
            item_reg.coord_x     <= coord_x;
            item_reg.coord_y     <= coord_y;
            item_reg.extent_w    <= extent_w;
            item_reg.extent_h    <= extent_h;
            item_reg.pixel_count <= pixel_count;
        end
    end

    drag_estimator u_est (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .est_valid  (est_valid),
        .est        (est)
    );

    drag_ledger u_ledger (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .est_valid (est_valid),
        .est       (est),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid     = res_valid;
    assign status        = res.status;
    assign est_pixels    = res.est_pixels;
    assign guard_enabled = res.guard_enabled;
    assign fault_total   = res.fault_total;

endmodule

FILE: sv/drag_cfg_regs.sv
// Configuration register file of the admission guard.
// Depends on drag_pkg.
module drag_cfg_regs
    import drag_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_w     <= RST_FRAME_W;
            cfg_reg.frame_h     <= RST_FRAME_H;
            cfg_reg.max_pixels  <= RST_MAX_PIXELS;
            cfg_reg.max_ops     <= RST_MAX_OPS;
            cfg_reg.fault_limit <= RST_FAULT_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_W:     cfg_reg.frame_w     <= cfg_data[FB_BITS-1:0];
                REG_FRAME_H:     cfg_reg.frame_h     <= cfg_data[FB_BITS-1:0];
                REG_MAX_PIXELS:  cfg_reg.max_pixels  <= cfg_data[PIXEL_BITS-1:0];
                REG_MAX_OPS:     cfg_reg.max_ops     <= cfg_data[OPS_BITS-1:0];
                REG_FAULT_LIMIT: cfg_reg.fault_limit <= cfg_data[FAULT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/drag_estimator.sv
// Geometry check and pixel cost estimate, registered into the ledger stage.
// Depends on drag_pkg.
module drag_estimator
    import drag_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  cfg_t  cfg,
    input  logic  item_valid,
    input  item_t item,
    output logic  est_valid,
    output est_t  est
);

    logic signed [CMP_BITS-1:0] xs, ys, ws, hs, fw, fh, dx, dy, adx, ady, line_len;
    logic in_x, in_y, in_w, in_h, pix_x, pix_y, pos_w, pos_h;
    logic [FB_BITS-1:0]   mul_a, mul_b;
    logic [PROD_BITS-1:0] prod;
    est_t est_next;
    logic est_valid_reg;
    est_t est_reg;

    always_comb
    begin
        xs = CMP_BITS'(item.coord_x);
        ys = CMP_BITS'(item.coord_y);
        ws = CMP_BITS'(item.extent_w);
        hs = CMP_BITS'(item.extent_h);
        fw = CMP_BITS'(cfg.frame_w);
        fh = CMP_BITS'(cfg.frame_h);

        in_x  = (xs >= -fw) && (xs <= fw);
        in_y  = (ys >= -fh) && (ys <= fh);
        in_w  = (ws >= -fw) && (ws <= fw);
        in_h  = (hs >= -fh) && (hs <= fh);
        pix_x = (xs >= 0) && (xs < fw);
        pix_y = (ys >= 0) && (ys < fh);
        pos_w = (ws > 0) && (ws <= fw);
        pos_h = (hs > 0) && (hs <= fh);

        dx  = ws - xs;
        dy  = hs - ys;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        line_len = ((adx > ady) ? adx : ady) + CMP_BITS'(1);

        mul_a = ws[FB_BITS-1:0];
        mul_b = ws[FB_BITS-1:0];
        if (item.command == CMD_CLEAR)
        begin
            mul_a = cfg.frame_w;
            mul_b = cfg.frame_h;
        end
        else if (item.command == CMD_RECT)
        begin
            mul_b = hs[FB_BITS-1:0];
        end
    end

    assign prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    always_comb
    begin
        est_next.kind    = item.kind;
        est_next.geom_ok = 1'b0;
        est_next.est     = '0;
        if (item.kind == KIND_RAW)
        begin
            est_next.geom_ok = 1'b1;
            est_next.est     = item.pixel_count;
        end
        else
        begin
            unique case (item.command)
                CMD_CLEAR:
                begin
                    est_next.geom_ok = 1'b1;
                    est_next.est     = PIXEL_BITS'(prod);
                end
                CMD_PIXEL:
                begin
                    est_next.geom_ok = pix_x && pix_y;
                    est_next.est     = PIXEL_BITS'(1);
                end
                CMD_LINE:
                begin
                    est_next.geom_ok = in_x && in_y && in_w && in_h;
                    est_next.est     = PIXEL_BITS'(line_len);
                end
                CMD_RECT:
                begin
                    est_next.geom_ok = in_x && in_y && pos_w && pos_h;
                    est_next.est     = PIXEL_BITS'(prod);
                end
                CMD_CIRCLE:
                begin
                    est_next.geom_ok = in_x && in_y && pos_w;
                    est_next.est     = PIXEL_BITS'(prod);
                end
                default:
                begin
                    est_next.geom_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            est_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && item_valid)
        begin
            est_reg <= est_next;
        end
    end

    assign est_valid = est_valid_reg;
    assign est       = est_reg;

endmodule

FILE: sv/drag_ledger.sv
// Guard state (enable, faults, op count, pixel total) and result register.
// Depends on drag_pkg and the assertion macro header.
`include "draw_request_admission_guard_core_assert.svh"

module drag_ledger
    import drag_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  cfg_t    cfg,
    input  logic    est_valid,
    input  est_t    est,
    output logic    res_valid,
    output result_t res
);

    logic                  enabled_reg, enabled_next;
    logic [FAULT_BITS-1:0] fault_count_reg, fault_count_next;
    logic [OPS_BITS-1:0]   op_count_reg, op_count_next;
    logic [PIXEL_BITS-1:0] pixel_total_reg, pixel_total_next;
    logic                  res_valid_reg;
    result_t               res_reg, res_next;

    logic [FAULT_BITS-1:0] fault_bumped;
    logic                  fault_disables;
    logic [PIXEL_BITS:0]   budget_sum;
    logic                  fits_item, over_budget;

    always_comb
    begin
        fault_bumped   = (fault_count_reg < cfg.fault_limit) ?
                         fault_count_reg + FAULT_BITS'(1) : fault_count_reg;
        fault_disables = (fault_bumped >= cfg.fault_limit);
        budget_sum     = {1'b0, pixel_total_reg} + {1'b0, est.est};
        fits_item      = ((est.kind == KIND_RAW) || est.geom_ok) &&
                         (est.est <= cfg.max_pixels);
        over_budget    = (op_count_reg >= cfg.max_ops) ||
                         (budget_sum > {1'b0, cfg.max_pixels});

        enabled_next     = enabled_reg;
        fault_count_next = fault_count_reg;
        op_count_next    = op_count_reg;
        pixel_total_next = pixel_total_reg;
        res_next.status     = ST_INVALID;
        res_next.est_pixels = '0;

        case (est.kind) inside
            KIND_RESET:
            begin
                enabled_next     = 1'b1;
                fault_count_next = '0;
                op_count_next    = '0;
                pixel_total_next = '0;
                res_next.status  = ST_OK;
            end
            KIND_DRAW, KIND_RAW:
            begin
                if (!enabled_reg)
                begin
                    res_next.status = ST_DISABLED;
                end
                else if (!fits_item || over_budget)
                begin
                    fault_count_next = fault_bumped;
                    enabled_next     = !fault_disables;
                    res_next.status  = fits_item ? ST_BUDGET : ST_INVALID;
                end
                else
                begin
                    op_count_next       = op_count_reg + OPS_BITS'(1);
                    pixel_total_next    = budget_sum[PIXEL_BITS-1:0];
                    res_next.status     = ST_OK;
                    res_next.est_pixels = est.est;
                end
            end
            default:
            begin
            end
        endcase

        res_next.guard_enabled = enabled_next;
        res_next.fault_total   = fault_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b1;
            fault_count_reg <= '0;
            op_count_reg    <= '0;
            pixel_total_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= est_valid;
            if (est_valid)
            begin
                enabled_reg     <= enabled_next;
                fault_count_reg <= fault_count_next;
                op_count_reg    <= op_count_next;
                pixel_total_reg <= pixel_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && est_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `DRAG_ASSERT_IMPLIES(a_ok_keeps_enabled, res_valid_reg && res_reg.status == ST_OK,
        res_reg.guard_enabled, "admitted result with guard disabled")
    `DRAG_ASSERT_IMPLIES(a_reject_zero_est, res_valid_reg && res_reg.status != ST_OK,
        res_reg.est_pixels == '0, "rejected result carries an estimate")
    `DRAG_ASSERT_IMPLIES(a_disabled_flag, res_valid_reg && res_reg.status == ST_DISABLED,
        !res_reg.guard_enabled, "disabled status while guard enabled")
    `DRAG_ASSERT_NEXT(a_reset_clears, adv && est_valid && est.kind == KIND_RESET,
        enabled_reg && fault_count_reg == '0 && op_count_reg == '0 && pixel_total_reg == '0,
        "reset transaction left state behind")

endmodule
